// ===== hw/rtl/first_fit_heap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFHA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types, codes and defaults for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int ADDR_W = 32;
    localparam int PADDR_W = 3;

    typedef logic [2:0] status_t;

    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_ZERO     = 3'd1;
    localparam status_t ST_NOSPACE  = 3'd2;
    localparam status_t ST_FULL     = 3'd3;
    localparam status_t ST_UNKNOWN  = 3'd4;
    localparam status_t ST_NULLFREE = 3'd5;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Register select bit of paddr: 0 heap_base, 1 heap_limit
    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic special;
        logic hit;
        logic miss;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic special;
        logic hit;
    } sts_t;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// ----------------------------------------------------------------------------
// ffha_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Request sequencer: capture, table scan, update and result transfer.
// ----------------------------------------------------------------------------
module ffha_ctrl #(
    parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    output logic                            out_valid,
    input  logic                            out_stall,
    input  ffha_pkg::sts_t                  sts,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0] count,
    output ffha_pkg::cmd_t                  cmd,
    output logic [$clog2(MAX_BLOCKS)-1:0]   rd_idx,
    output logic [$clog2(MAX_BLOCKS)-1:0]   hit_idx
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_HIT     = 3'd2;
    localparam logic [2:0] S_MISS    = 3'd3;
    localparam logic [2:0] S_DELIVER = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [IDX_W-1:0] chk_idx_reg, chk_idx_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_idx_next   = chk_idx_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    issue_next     = '0;
                    chk_valid_next = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.special)
                begin
                    cmd.special = 1'b1;
                    state_next  = S_DELIVER;
                end
                else if (chk_valid_reg && sts.hit)
                begin
                    state_next = S_HIT;
                end
                else if (issue_reg >= count)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    // issue the next entry, check the one read last cycle
                    cmd.rd_en      = 1'b1;
                    chk_idx_next   = issue_reg[IDX_W-1:0];
                    chk_valid_next = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                end
            end
            S_HIT:
            begin
                cmd.hit    = 1'b1;
                state_next = S_DELIVER;
            end
            S_MISS:
            begin
                cmd.miss   = 1'b1;
                state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign rd_idx    = issue_reg[IDX_W-1:0];
    assign hit_idx   = chk_idx_reg;

endmodule

// ===== hw/rtl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Block table, program break, match logic and result registers.
// ----------------------------------------------------------------------------
module ffha_dp #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffha_pkg::cmd_t                  cmd,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   rd_idx,
    input  logic [$clog2(MAX_BLOCKS)-1:0]   hit_idx,
    input  logic                            opcode,
    input  logic [31:0]                     request_size,
    input  logic [31:0]                     payload_address,
    input  logic [31:0]                     heap_base,
    input  logic [31:0]                     heap_limit,
    output ffha_pkg::sts_t                  sts,
    output logic [$clog2(MAX_BLOCKS+1)-1:0] count,
    output logic [31:0]                     result_address,
    output ffha_pkg::status_t               status
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic                  op_reg;
    logic [31:0]           size_reg;
    logic [31:0]           addr_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [31:0]           brk_reg, brk_next;
    logic [31:0]           res_addr_reg, res_addr_next;
    ffha_pkg::status_t     res_status_reg, res_status_next;
    logic [31:0]           out_addr_reg;
    ffha_pkg::status_t     out_status_reg;

    ffha_pkg::entry_t      rd_entry;
    ffha_pkg::entry_t      wr_entry;
    logic                  we;
    logic [IDX_W-1:0]      waddr;

    logic [31:0]           brk_cur;
    logic [33:0]           append_end;
    logic                  is_last;
    logic                  table_full;
    logic                  no_space;

    ffha_ram #(
        .WIDTH (ffha_pkg::ENTRY_W),
        .DEPTH (MAX_BLOCKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (rd_idx),
        .rdata (rd_entry)
    );

    // Break is heap_base only while the table is empty
    assign brk_cur    = (count_reg == '0) ? heap_base : brk_reg;
    assign append_end = {2'b00, brk_cur} + 34'(HEADER_BYTES) + {2'b00, size_reg};
    assign is_last    = (CNT_W'(hit_idx) == (count_reg - CNT_W'(1)));
    assign table_full = (count_reg == CNT_W'(MAX_BLOCKS));
    assign no_space   = (append_end > {2'b00, heap_limit});

    always_comb
    begin
        sts.special = ((op_reg == ffha_pkg::OP_ALLOC) && (size_reg == '0)) ||
                      ((op_reg == ffha_pkg::OP_FREE) && (addr_reg == '0));
        if (op_reg == ffha_pkg::OP_ALLOC)
        begin
            sts.hit = rd_entry.free && (rd_entry.size >= size_reg);
        end
        else
        begin
            sts.hit = (({1'b0, rd_entry.start} + 33'(HEADER_BYTES)) == {1'b0, addr_reg});
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        brk_next        = brk_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        we              = 1'b0;
        waddr           = hit_idx;
        wr_entry        = rd_entry;
        if (cmd.special)
        begin
            res_addr_next   = '0;
            res_status_next = (op_reg == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_ZERO
                                                             : ffha_pkg::ST_NULLFREE;
        end
        else if (cmd.hit)
        begin
            res_status_next = ffha_pkg::ST_OK;
            if (op_reg == ffha_pkg::OP_ALLOC)
            begin
                // reuse the free block whole
                we             = 1'b1;
                wr_entry.free  = 1'b0;
                res_addr_next  = rd_entry.start + 32'(HEADER_BYTES);
            end
            else
            begin
                res_addr_next = '0;
                if (is_last)
                begin
                    // drop the tail block, break falls to its header
                    count_next = count_reg - CNT_W'(1);
                    brk_next   = rd_entry.start;
                end
                else
                begin
                    we            = 1'b1;
                    wr_entry.free = 1'b1;
                end
            end
        end
        else if (cmd.miss)
        begin
            res_addr_next = '0;
            if (op_reg == ffha_pkg::OP_FREE)
            begin
                res_status_next = ffha_pkg::ST_UNKNOWN;
            end
            else if (table_full)
            begin
                res_status_next = ffha_pkg::ST_FULL;
            end
            else if (no_space)
            begin
                res_status_next = ffha_pkg::ST_NOSPACE;
            end
            else
            begin
                // append at the break
                we              = 1'b1;
                waddr           = count_reg[IDX_W-1:0];
                wr_entry.start  = brk_cur;
                wr_entry.size   = size_reg;
                wr_entry.free   = 1'b0;
                count_next      = count_reg + CNT_W'(1);
                brk_next        = append_end[31:0];
                res_addr_next   = brk_cur + 32'(HEADER_BYTES);
                res_status_next = ffha_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        brk_reg        <= brk_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            size_reg <= request_size;
            addr_reg <= payload_address;
        end
        if (cmd.load_out)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign count          = count_reg;
    assign result_address = out_addr_reg;
    assign status         = out_status_reg;

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap block allocator with a program break and APB config port.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid/in_stall): opcode, request_size, payload_address.
//   A transfer happens on a rising edge with in_valid high and in_stall low.
//   Result channel (out_valid/out_stall): result_address, status, exactly one
//   result per request, in request order.
//   After transfer a request scans the table entries, one per cycle through
//   the table RAM's single read port (at most MAX_BLOCKS), then resolves
//   the hit or miss; zero-size allocates and null frees skip the scan.
//   One request is in flight at a time: the next is taken the cycle after
//   its result is loaded.
//   A result waits in an output register; while the receiver stalls it holds,
//   and the next request is still taken and worked up to its result.
//   Reset clears the block count (empty heap), heap_base to 0 and heap_limit
//   to all ones. Table contents need no clearing.
//   heap_base (paddr 0) and heap_limit (paddr 4) must be written only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // config port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffha_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // request channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [31:0]                  request_size,
    input  logic [31:0]                  payload_address,
    // result channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [31:0]                  result_address,
    output logic [2:0]                   status
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    logic [31:0]      heap_base_reg, heap_base_next;
    logic [31:0]      heap_limit_reg, heap_limit_next;
    logic             cfg_wr;

    ffha_pkg::cmd_t   cmd;
    ffha_pkg::sts_t   sts;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] hit_idx;

    // Config writes complete in the access phase; the byte offset is ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        heap_base_next  = heap_base_reg;
        heap_limit_next = heap_limit_reg;
        if (cfg_wr)
        begin
            case (paddr[2])
                ffha_pkg::REG_HEAP_BASE:  heap_base_next  = pwdata;
                ffha_pkg::REG_HEAP_LIMIT: heap_limit_next = pwdata;
                default:                  heap_base_next  = heap_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ffha_pkg::REG_HEAP_BASE:  prdata = heap_base_reg;
            ffha_pkg::REG_HEAP_LIMIT: prdata = heap_limit_reg;
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg  <= '0;
            heap_limit_reg <= '1;
        end
        else
        begin
            heap_base_reg  <= heap_base_next;
            heap_limit_reg <= heap_limit_next;
        end
    end

    // Sequencer: hold in_stall while a request is in flight
    ffha_ctrl #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .count     (count),
        .cmd       (cmd),
        .rd_idx    (rd_idx),
        .hit_idx   (hit_idx)
    );

    // Table, break and result registers
    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_idx          (rd_idx),
        .hit_idx         (hit_idx),
        .opcode          (opcode),
        .request_size    (request_size),
        .payload_address (payload_address),
        .heap_base       (heap_base_reg),
        .heap_limit      (heap_limit_reg),
        .sts             (sts),
        .count           (count),
        .result_address  (result_address),
        .status          (status)
    );

endmodule

// ===== hw/rtl/first_fit_heap_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_address,
    input logic [2:0]  status
);

    `FFHA_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, in_valid && !in_stall, in_stall, "request transfer did not stall the next cycle")
    `FFHA_ASSERT_SAME(a_status_range, clk, rst_n, out_valid, status <= ffha_pkg::ST_NULLFREE, "status code out of range")
    `FFHA_ASSERT_SAME(a_fail_zero_addr, clk, rst_n, out_valid && (status != ffha_pkg::ST_OK), result_address == '0, "failed request returned a nonzero address")
    `FFHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(result_address) && $stable(status), "stalled result changed")

endmodule

bind first_fit_heap_allocator first_fit_heap_allocator_checker u_checker (.*);
